[src/raid6_pkg.sv]
`default_nettype none
package raid6_pkg;

    localparam int BLOCK_WORDS_DEF = 512;
    localparam int WORD_SPAN       = 512;
    localparam int LANES           = 8;
    localparam logic [7:0] GF_POLY_LOW = 8'h1D;

    typedef logic [7:0] gf_table_t [256];

    function automatic logic [7:0] gf_times2(input logic [7:0] a);
        logic [7:0] r;
        r = {a[6:0], 1'b0};
        if (a[7]) begin
            r = r ^ GF_POLY_LOW;
        end
        return r;
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] r;
        logic [7:0] x;
        r = 8'h00;
        x = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                r = r ^ x;
            end
            x = gf_times2(x);
        end
        return r;
    endfunction

    function automatic gf_table_t gf_build_pow();
        gf_table_t t;
        logic [7:0] r;
        r = 8'h01;
        for (int e = 0; e < 256; e++) begin
            t[e] = r;
            r = gf_times2(r);
        end
        return t;
    endfunction

    // generator powers: g^e for every disk index
    localparam gf_table_t GEN_POW = gf_build_pow();

endpackage
`default_nettype wire

[src/raid6_pq_syndrome_generator_core.sv]
// Stage 1 registers each beat; the output register takes last-disk results.
// Throughput: one beat per cycle unless a last-disk beat waits on the output;
// accumulator RMW: a registered read, then a write, with write forwarding.
// Reset (aresetn, synchronous, active low) clears the pipeline and output
// valids; the P and Q accumulator memories are not cleared.
`default_nettype none
module raid6_pq_syndrome_generator_core
    import raid6_pkg::*;
#(
    parameter int BLOCK_WORDS = BLOCK_WORDS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [63:0] s_data_word,
    input  wire logic [7:0]  s_disk_index,
    input  wire logic [8:0]  s_word_index,
    input  wire logic        s_first_disk,
    input  wire logic        s_last_disk,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [63:0]      m_p_word,
    output logic [63:0]      m_q_word,
    output logic [8:0]       m_out_word_index
);

    localparam int MEM_DEPTH = (BLOCK_WORDS < WORD_SPAN) ? BLOCK_WORDS : WORD_SPAN;
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    logic [63:0] p_mem [MEM_DEPTH];
    logic [63:0] q_mem [MEM_DEPTH];

    logic        s1_valid_reg;
    logic [63:0] s1_data_reg;
    logic [7:0]  s1_coef_reg;
    logic [8:0]  s1_idx_reg;
    logic        s1_first_reg;
    logic        s1_last_reg;

    logic [63:0] p_rd_reg;
    logic [63:0] q_rd_reg;

    logic        wr_valid_reg;
    logic [8:0]  wr_idx_reg;
    logic [63:0] wr_p_reg;
    logic [63:0] wr_q_reg;

    logic        m_valid_reg;
    logic [63:0] m_p_reg;
    logic [63:0] m_q_reg;
    logic [8:0]  m_idx_reg;

    logic        in_range;
    logic        s_take;
    logic        out_free;
    logic        s1_adv;
    logic        s1_fire;
    logic        fwd_hit;
    logic [63:0] p_old;
    logic [63:0] q_old;
    logic [63:0] q_term;
    logic [63:0] p_next;
    logic [63:0] q_next;

    assign in_range = 32'(s_word_index) < BLOCK_WORDS;
    assign out_free = !m_valid_reg || m_ready;
    assign s1_adv   = !s1_valid_reg || !s1_last_reg || out_free;
    assign s1_fire  = s1_valid_reg && s1_adv;
    assign s_ready  = s1_adv;
    assign s_take   = s_valid && s_ready && in_range;

    assign fwd_hit = wr_valid_reg && (wr_idx_reg == s1_idx_reg);
    assign p_old   = fwd_hit ? wr_p_reg : p_rd_reg;
    assign q_old   = fwd_hit ? wr_q_reg : q_rd_reg;

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            q_term[8*k +: 8] = gf_mul(s1_data_reg[8*k +: 8], s1_coef_reg);
        end
    end

    assign p_next = s1_first_reg ? s1_data_reg : (p_old ^ s1_data_reg);
    assign q_next = s1_first_reg ? q_term : (q_old ^ q_term);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            wr_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s1_adv) begin
                s1_valid_reg <= s_take;
                wr_valid_reg <= s1_valid_reg;
            end
            if (out_free) begin
                m_valid_reg <= s1_fire && s1_last_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            s1_data_reg  <= s_data_word;
            s1_coef_reg  <= GEN_POW[s_disk_index];
            s1_idx_reg   <= s_word_index;
            s1_first_reg <= s_first_disk;
            s1_last_reg  <= s_last_disk;
        end
        if (s1_fire) begin
            wr_idx_reg <= s1_idx_reg;
            wr_p_reg   <= p_next;
            wr_q_reg   <= q_next;
        end
        if (out_free && s1_fire && s1_last_reg) begin
            m_p_reg   <= p_next;
            m_q_reg   <= q_next;
            m_idx_reg <= s1_idx_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            p_rd_reg <= p_mem[s_word_index[ADDR_W-1:0]];
            q_rd_reg <= q_mem[s_word_index[ADDR_W-1:0]];
        end
        if (s1_fire) begin
            p_mem[s1_idx_reg[ADDR_W-1:0]] <= p_next;
            q_mem[s1_idx_reg[ADDR_W-1:0]] <= q_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_p_word         = m_p_reg;
    assign m_q_word         = m_q_reg;
    assign m_out_word_index = m_idx_reg;

`ifndef SYNTHESIS
    a_idle_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s1_valid_reg |-> s_ready)
        else $error("input not ready with empty pipeline");

    a_drop_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !in_range) |=> !s1_valid_reg)
        else $error("out-of-range beat entered pipeline");

    a_first_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_fire && s1_first_reg && s1_last_reg)
        |=> (m_valid_reg && (m_p_reg == $past(s1_data_reg))))
        else $error("fresh single-disk P word not emitted");
`endif

endmodule
`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps
module tb;
    import raid6_pkg::BLOCK_WORDS_DEF;
    import raid6_pkg::LANES;
    import raid6_pkg::GF_POLY_LOW;

    localparam int RANDOM_BEATS   = 1400;
    localparam int HOLD_CYCLES    = 250;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 20;

    typedef struct {
        logic [63:0] p;
        logic [63:0] q;
        logic [8:0]  pos;
    } parity_t;

    class syndrome_board;
        logic [63:0] p_sum [BLOCK_WORDS_DEF];
        logic [63:0] q_sum [BLOCK_WORDS_DEF];
        bit          written [BLOCK_WORDS_DEF];
        parity_t     parity_due [$];
        int          bad_beats;

        // multiply each byte lane by g^e, one doubling per step of the exponent
        function logic [63:0] scale_lanes(logic [63:0] w, logic [7:0] e);
            logic [63:0] r;
            logic [7:0]  b;
            r = '0;
            for (int k = 0; k < LANES; k++) begin
                b = w[8*k +: 8];
                for (int i = 0; i < int'(e); i++) begin
                    b = {b[6:0], 1'b0} ^ (b[7] ? GF_POLY_LOW : 8'h00);
                end
                r[8*k +: 8] = b;
            end
            return r;
        endfunction

        function void note_beat(logic [63:0] d, logic [7:0] disk, logic [8:0] pos,
                                logic first, logic last);
            logic [63:0] qterm;
            parity_t     exp_w;
            qterm = scale_lanes(d, disk);
            if (first) begin
                p_sum[pos] = d;
                q_sum[pos] = qterm;
            end else begin
                p_sum[pos] = p_sum[pos] ^ d;
                q_sum[pos] = q_sum[pos] ^ qterm;
            end
            written[pos] = 1'b1;
            if (last) begin
                exp_w.p   = p_sum[pos];
                exp_w.q   = q_sum[pos];
                exp_w.pos = pos;
                parity_due.push_back(exp_w);
            end
        endfunction

        function void check_beat(logic [63:0] p, logic [63:0] q, logic [8:0] pos);
            parity_t exp_w;
            if (parity_due.size() == 0) begin
                bad_beats++;
                if (bad_beats <= 10) begin
                    $display("unexpected beat: p %h q %h word %0d", p, q, pos);
                end
                return;
            end
            exp_w = parity_due.pop_front();
            if (p !== exp_w.p || q !== exp_w.q || pos !== exp_w.pos) begin
                bad_beats++;
                if (bad_beats <= 10) begin
                    $display("mismatch: p exp %h got %h, q exp %h got %h, word exp %0d got %0d",
                             exp_w.p, p, exp_w.q, q, exp_w.pos, pos);
                end
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [63:0] s_data_word;
    logic [7:0]  s_disk_index;
    logic [8:0]  s_word_index;
    logic        s_first_disk;
    logic        s_last_disk;
    logic        m_valid;
    logic        m_ready;
    logic [63:0] m_p_word;
    logic [63:0] m_q_word;
    logic [8:0]  m_out_word_index;

    syndrome_board sb;
    int  beats_sent;
    bit  gaps_on;
    bit  stall_on;
    bit  squeeze_req;
    int  quiet;

    raid6_pq_syndrome_generator_core DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_word     (s_data_word),
        .s_disk_index    (s_disk_index),
        .s_word_index    (s_word_index),
        .s_first_disk    (s_first_disk),
        .s_last_disk     (s_last_disk),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_p_word        (m_p_word),
        .m_q_word        (m_q_word),
        .m_out_word_index(m_out_word_index)
    );

    always #5 aclk = ~aclk;

    // Offer one beat and hold it until the handshake; returns at the accepting edge.
    task automatic send_beat(input logic [63:0] d, input logic [7:0] disk,
                             input logic [8:0] pos, input logic first, input logic last);
        while (gaps_on && $urandom_range(99) < 11) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_data_word  <= d;
        s_disk_index <= disk;
        s_word_index <= pos;
        s_first_disk <= first;
        s_last_disk  <= last;
        @(negedge aclk);
        while (!s_ready) @(negedge aclk);
        @(posedge aclk);
        beats_sent++;
    endtask

    task automatic run_stripe(input logic [8:0] pos, input int n);
        for (int i = 0; i < n; i++) begin
            send_beat({$urandom, $urandom}, 8'($urandom_range(255)), pos, i == 0, i == n - 1);
        end
    endtask

    task automatic run_pair(input logic [8:0] a, input int n);
        logic [8:0] b;
        b = a ^ 9'($urandom_range(1, 511));
        for (int i = 0; i < n; i++) begin
            send_beat({$urandom, $urandom}, 8'($urandom_range(255)), a, i == 0, i == n - 1);
            send_beat({$urandom, $urandom}, 8'($urandom_range(255)), b, i == 0, i == n - 1);
        end
    endtask

    task automatic noise_beat();
        logic [8:0] pos;
        logic       first;
        pos   = 9'($urandom_range(511));
        first = $urandom_range(1) || !sb.written[pos];
        send_beat({$urandom, $urandom}, 8'($urandom_range(255)), pos, first,
                  1'($urandom_range(1)));
    endtask

    task automatic squeeze_burst();
        gaps_on     = 1'b0;
        squeeze_req = 1'b1;
        repeat (40) begin
            send_beat({$urandom, $urandom}, 8'($urandom_range(255)),
                      9'($urandom_range(511)), 1'b1, 1'b1);
        end
    endtask

    // note input beats and check result beats on the falling edge, before the accepting edge
    initial begin
        forever begin
            @(negedge aclk);
            if (aresetn && s_valid && s_ready) begin
                sb.note_beat(s_data_word, s_disk_index, s_word_index, s_first_disk,
                             s_last_disk);
            end
            if (aresetn && m_valid && m_ready) begin
                sb.check_beat(m_p_word, m_q_word, m_out_word_index);
            end
        end
    end

    initial begin
        int hold_left;
        hold_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (squeeze_req) begin
                squeeze_req = 1'b0;
                hold_left   = HOLD_CYCLES - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= !(stall_on && $urandom_range(99) < 11);
            end
        end
    end

    initial begin
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(negedge aclk);
            if (aresetn && !((s_valid && s_ready) || (m_valid && m_ready))) begin
                quiet++;
            end else begin
                quiet = 0;
            end
        end
        $display("raid6_pq_syndrome_generator_core regression: fail");
        $finish;
    end

    initial begin
        bit squeezed;
        int pick;
        sb          = new();
        beats_sent  = 0;
        gaps_on     = 1'b1;
        stall_on    = 1'b1;
        squeeze_req = 1'b0;
        squeezed    = 1'b0;
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_data_word  <= '0;
        s_disk_index <= '0;
        s_word_index <= '0;
        s_first_disk <= 1'b0;
        s_last_disk  <= 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_beat(64'hFFFF_FFFF_FFFF_FFFF, 8'd0,   9'd0,   1'b1, 1'b1);
        send_beat(64'h8080_8080_8080_8080, 8'd255, 9'd511, 1'b1, 1'b1);
        send_beat(64'h0000_0000_0000_0000, 8'd128, 9'd256, 1'b1, 1'b1);
        // disk 255 weighs like disk 0, so Q cancels
        send_beat(64'hA5A5_A5A5_5A5A_5A5A, 8'd0,   9'h100, 1'b1, 1'b0);
        send_beat(64'hA5A5_A5A5_5A5A_5A5A, 8'd255, 9'h100, 1'b0, 1'b1);
        send_beat(64'hFFFF_FFFF_FFFF_FFFF, 8'd254, 9'd511, 1'b1, 1'b0);
        send_beat(64'h0123_4567_89AB_CDEF, 8'd1,   9'd511, 1'b0, 1'b0);
        send_beat(64'hFEDC_BA98_7654_3210, 8'd255, 9'd511, 1'b0, 1'b1);
        // keep accumulating after emission
        send_beat(64'h8000_0000_0000_0001, 8'd8,   9'd511, 1'b0, 1'b1);
        send_beat(64'hFFFF_FFFF_FFFF_FFFF, 8'd0,   9'h0AA, 1'b1, 1'b0);
        send_beat(64'h8181_8181_8181_8181, 8'd1,   9'h0AA, 1'b0, 1'b0);
        send_beat(64'h7F7F_7F7F_7F7F_7F7F, 8'd2,   9'h0AA, 1'b0, 1'b0);
        send_beat(64'h0102_0408_1020_4080, 8'd3,   9'h0AA, 1'b0, 1'b1);
        send_beat(64'h5555_5555_5555_5555, 8'd100, 9'h155, 1'b1, 1'b0);
        send_beat(64'hAAAA_AAAA_AAAA_AAAA, 8'd200, 9'h155, 1'b0, 1'b0);
        send_beat(64'hFFFF_0000_FFFF_0000, 8'd127, 9'h155, 1'b0, 1'b1);
        send_beat({$urandom, $urandom},    8'd3,   9'd1,   1'b1, 1'b0);
        send_beat({$urandom, $urandom},    8'd4,   9'd2,   1'b1, 1'b0);
        send_beat({$urandom, $urandom},    8'd5,   9'd1,   1'b0, 1'b1);
        send_beat({$urandom, $urandom},    8'd6,   9'd2,   1'b0, 1'b1);

        while (beats_sent < RANDOM_BEATS + 20) begin
            gaps_on  = !(beats_sent >= 300 && beats_sent < 600);
            stall_on = gaps_on;
            if (!squeezed && beats_sent >= 800) begin
                squeezed = 1'b1;
                squeeze_burst();
            end else begin
                pick = $urandom_range(99);
                if (pick < 65) begin
                    run_stripe(9'($urandom_range(511)), $urandom_range(1, 6));
                end else if (pick < 80) begin
                    run_pair(9'($urandom_range(511)), $urandom_range(1, 5));
                end else begin
                    noise_beat();
                end
            end
        end
        s_valid <= 1'b0;

        while (sb.parity_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.bad_beats == 0 && sb.parity_due.size() == 0) begin
            $display("raid6_pq_syndrome_generator_core regression: pass");
        end else begin
            $display("raid6_pq_syndrome_generator_core regression: fail");
        end
        $finish;
    end
endmodule

[files.f]
src/raid6_pkg.sv
src/raid6_pq_syndrome_generator_core.sv
tb/tb.sv
